// ----- rtl/bmrf_pkg.sv -----
// Shared types and constants for the border marker run finder.
package bmrf_pkg;

  localparam int unsigned OUT_W = 16;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW = 3;
  localparam int unsigned FIFO_CW = 4;

  typedef enum logic [1:0] {
    CFG_BYTE_SEL = 2'd0,
    CFG_MASK     = 2'd1,
    CFG_MATCH    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] finish;
    logic             last_flag;
  } range_t;

  typedef struct packed {
    logic   v0;
    range_t r0;
    logic   v1;
    range_t r1;
  } push_t;

endpackage

// ----- rtl/border_marker_run_finder_core.sv -----
// Top level of the border marker run finder: config registers, input stage, queue.
// Pixel path: an accepted pixel word is registered in the input stage, then classified
// and its ranges written into the result queue, from whose head they are offered.
// Throughput: one pixel per cycle while in_stall_o is low; the eight-entry result queue and its single read
// port set the rate when pixels close runs faster than ranges are taken.
// Reset clears run state, queue and input stage; registers return to byte 3, 0xFF, 0xFF.
module border_marker_run_finder_core #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_word_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] range_start_o,
  output logic [15:0] range_end_o,
  output logic        final_range_o
);

  logic [1:0]  byte_sel_q;
  logic [7:0]  mask_q;
  logic [7:0]  match_q;

  logic        pend_q;
  logic [31:0] word_q;
  logic        last_q;

  logic                         accept;
  logic                         hit;
  bmrf_pkg::push_t              push;
  bmrf_pkg::range_t             head;
  logic [bmrf_pkg::FIFO_CW-1:0] count;
  logic [bmrf_pkg::FIFO_CW-1:0] reserved;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_sel_q <= 2'd3;
      mask_q     <= 8'hFF;
      match_q    <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (bmrf_pkg::cfg_idx_e'(cfg_index_i))
        bmrf_pkg::CFG_BYTE_SEL: byte_sel_q <= cfg_data_i[1:0];
        bmrf_pkg::CFG_MASK:     mask_q     <= cfg_data_i;
        bmrf_pkg::CFG_MATCH:    match_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // room for two words from the staged pixel and two from the incoming one
  assign reserved   = count + bmrf_pkg::FIFO_CW'({pend_q, 1'b0});
  assign in_stall_o = reserved > bmrf_pkg::FIFO_CW'(bmrf_pkg::FIFO_DEPTH - 4);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= pixel_word_i;
      last_q <= last_pixel_i;
    end
  end

  bmrf_match u_match (
    .pixel_word_i (word_q),
    .byte_sel_i   (byte_sel_q),
    .mask_i       (mask_q),
    .match_i      (match_q),
    .hit_o        (hit)
  );

  bmrf_tracker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pend_q),
    .hit_i   (hit),
    .last_i  (last_q),
    .push_o  (push)
  );

  bmrf_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (count)
  );

  assign range_start_o = head.start;
  assign range_end_o   = head.finish;
  assign final_range_o = head.last_flag;

endmodule

// ----- rtl/bmrf_match.sv -----
// Byte select, mask and compare that classifies one border pixel.
module bmrf_match (
  input  logic [31:0] pixel_word_i,
  input  logic [1:0]  byte_sel_i,
  input  logic [7:0]  mask_i,
  input  logic [7:0]  match_i,
  output logic        hit_o
);

  logic [7:0] byte_sel;

  always_comb begin
    case (byte_sel_i)
      2'd0:    byte_sel = pixel_word_i[7:0];
      2'd1:    byte_sel = pixel_word_i[15:8];
      2'd2:    byte_sel = pixel_word_i[23:16];
      default: byte_sel = pixel_word_i[31:24];
    endcase
  end

  assign hit_o = (byte_sel & mask_i) == match_i;

endmodule

// ----- rtl/bmrf_tracker.sv -----
// Run tracking state and range generation for one pixel per cycle in which valid_i is high.
module bmrf_tracker #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            hit_i,
  input  logic            last_i,
  output bmrf_pkg::push_t push_o
);

  localparam int unsigned PosMaxI = (1 << POSITION_BITS) - 4;
  localparam logic [POSITION_BITS-1:0] PosMax = POSITION_BITS'(PosMaxI);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     in_run_q, in_run_d;
  logic [POSITION_BITS-1:0] run_begin_q, run_begin_d;
  logic                     held_valid_q, held_valid_d;
  logic [POSITION_BITS-1:0] held_begin_q, held_begin_d;
  logic [POSITION_BITS-1:0] held_finish_q, held_finish_d;

  logic [POSITION_BITS-1:0] pos_next;
  logic                     run_now;
  logic [POSITION_BITS-1:0] rb_now;
  logic                     close_a, close_b, closed;
  logic [POSITION_BITS-1:0] c_begin, c_finish;
  logic                     hv_new;
  logic [POSITION_BITS-1:0] hb_new, hf_new;

  always_comb begin
    pos_next = (pos_q >= PosMax) ? PosMax : pos_q + 1'b1;
    run_now  = hit_i;
    rb_now   = in_run_q ? run_begin_q : pos_q;
    close_a  = in_run_q && !hit_i;
    close_b  = last_i && run_now;
    closed   = close_a || close_b;
    c_begin  = close_a ? run_begin_q : rb_now;
    c_finish = close_a ? pos_q : pos_next;
    hv_new   = held_valid_q || closed;
    hb_new   = closed ? c_begin : held_begin_q;
    hf_new   = closed ? c_finish : held_finish_q;

    push_o.v0           = valid_i && closed && held_valid_q;
    push_o.r0.start     = bmrf_pkg::OUT_W'(held_begin_q);
    push_o.r0.finish    = bmrf_pkg::OUT_W'(held_finish_q);
    push_o.r0.last_flag = 1'b0;
    push_o.v1           = valid_i && last_i;
    push_o.r1.start     = hv_new ? bmrf_pkg::OUT_W'(hb_new) : '0;
    push_o.r1.finish    = hv_new ? bmrf_pkg::OUT_W'(hf_new) : bmrf_pkg::OUT_W'(pos_next);
    push_o.r1.last_flag = 1'b1;

    pos_d         = pos_q;
    in_run_d      = in_run_q;
    run_begin_d   = run_begin_q;
    held_valid_d  = held_valid_q;
    held_begin_d  = held_begin_q;
    held_finish_d = held_finish_q;
    if (valid_i) begin
      if (last_i) begin
        pos_d         = '0;
        in_run_d      = 1'b0;
        run_begin_d   = '0;
        held_valid_d  = 1'b0;
        held_begin_d  = '0;
        held_finish_d = '0;
      end else begin
        pos_d         = pos_next;
        in_run_d      = run_now;
        run_begin_d   = rb_now;
        held_valid_d  = hv_new;
        held_begin_d  = hb_new;
        held_finish_d = hf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      in_run_q      <= 1'b0;
      run_begin_q   <= '0;
      held_valid_q  <= 1'b0;
      held_begin_q  <= '0;
      held_finish_q <= '0;
    end else begin
      pos_q         <= pos_d;
      in_run_q      <= in_run_d;
      run_begin_q   <= run_begin_d;
      held_valid_q  <= held_valid_d;
      held_begin_q  <= held_begin_d;
      held_finish_q <= held_finish_d;
    end
  end

endmodule

// ----- rtl/bmrf_out_fifo.sv -----
// Result queue taking up to two range words per cycle and giving out one.
module bmrf_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bmrf_pkg::push_t                push_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output bmrf_pkg::range_t               head_o,
  output logic [bmrf_pkg::FIFO_CW-1:0]   count_o
);

  bmrf_pkg::range_t mem_q [bmrf_pkg::FIFO_DEPTH];

  logic [bmrf_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [bmrf_pkg::FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [bmrf_pkg::FIFO_CW-1:0] count_q, count_d;
  logic [bmrf_pkg::FIFO_AW-1:0] wr_sec;
  logic                         pop;

  assign pop    = pop_i && (count_q != '0);
  assign wr_sec = push_i.v0 ? wr_ptr_q + 1'b1 : wr_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + bmrf_pkg::FIFO_AW'(push_i.v0) + bmrf_pkg::FIFO_AW'(push_i.v1);
    rd_ptr_d = rd_ptr_q + bmrf_pkg::FIFO_AW'(pop);
    count_d  = count_q + bmrf_pkg::FIFO_CW'(push_i.v0) + bmrf_pkg::FIFO_CW'(push_i.v1)
             - bmrf_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_sec] <= push_i.r1;
    end
  end

  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- verif/bmrf_range_checker.sv -----
// Range checker for the border marker run finder: predicts ranges from accepted words.
module bmrf_range_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] pixel_word_i,
  input  logic        last_pixel_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] range_start_i,
  input  logic [15:0] range_end_i,
  input  logic        final_range_i,
  output int unsigned mismatches_o,
  output int unsigned ranges_due_o,
  output int unsigned ranges_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] POS_CAP = 16'hFFFC;

  logic [1:0]       sel_q;
  logic [7:0]       mask_q;
  logic [7:0]       match_q;
  logic [15:0]      pos_q;
  logic             in_run_q;
  logic [15:0]      run_begin_q;
  logic             held_q;
  logic [15:0]      held_begin_q;
  logic [15:0]      held_finish_q;
  bmrf_pkg::range_t ranges_due[$];
  bmrf_pkg::range_t due;
  int unsigned      mismatch_count = 0;
  int unsigned      seen_count = 0;

  function automatic logic [15:0] pos_next(input logic [15:0] p);
    return (p >= POS_CAP) ? POS_CAP : p + 16'd1;
  endfunction

  task automatic clear_pass();
    pos_q         = '0;
    in_run_q      = 1'b0;
    run_begin_q   = '0;
    held_q        = 1'b0;
    held_begin_q  = '0;
    held_finish_q = '0;
  endtask

  task automatic classify_pixel(input logic [31:0] word, input logic last);
    logic [7:0]  tested;
    logic        hit;
    logic        closed;
    logic [15:0] c_begin;
    logic [15:0] c_finish;
    logic [15:0] p;
    p        = pos_q;
    tested   = word[8*sel_q +: 8];
    hit      = (tested & mask_q) == match_q;
    closed   = 1'b0;
    c_begin  = '0;
    c_finish = '0;
    if (in_run_q && !hit) begin
      closed   = 1'b1;
      c_begin  = run_begin_q;
      c_finish = p;
      in_run_q = 1'b0;
    end else if (!in_run_q && hit) begin
      in_run_q    = 1'b1;
      run_begin_q = p;
    end
    if (last && in_run_q) begin
      closed   = 1'b1;
      c_begin  = run_begin_q;
      c_finish = pos_next(p);
      in_run_q = 1'b0;
    end
    if (closed) begin
      if (held_q) ranges_due.push_back('{held_begin_q, held_finish_q, 1'b0});
      held_q        = 1'b1;
      held_begin_q  = c_begin;
      held_finish_q = c_finish;
    end
    if (last) begin
      if (held_q) begin
        ranges_due.push_back('{held_begin_q, held_finish_q, 1'b1});
      end else begin
        ranges_due.push_back('{16'd0, pos_next(p), 1'b1});
      end
      clear_pass();
    end else begin
      pos_q = pos_next(p);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   = 2'd3;
      mask_q  = 8'hFF;
      match_q = 8'hFF;
      clear_pass();
      ranges_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bmrf_pkg::CFG_BYTE_SEL: sel_q = cfg_data_i[1:0];
          bmrf_pkg::CFG_MASK:     mask_q = cfg_data_i;
          bmrf_pkg::CFG_MATCH:    match_q = cfg_data_i;
          default:      ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen_count++;
        if (ranges_due.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: range %0d..%0d final %0b with none expected", $realtime,
                     range_start_i, range_end_i, final_range_i);
          end
          mismatch_count++;
        end else begin
          due = ranges_due.pop_front();
          if (range_start_i !== due.start || range_end_i !== due.finish ||
              final_range_i !== due.last_flag) begin
            if (mismatch_count < 10) begin
              $display("%0t: expected %0d..%0d final %0b, got %0d..%0d final %0b",
                       $realtime, due.start, due.finish, due.last_flag,
                       range_start_i, range_end_i, final_range_i);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) classify_pixel(pixel_word_i, last_pixel_i);
    end
    mismatches_o  <= mismatch_count;
    ranges_due_o  <= ranges_due.size();
    ranges_seen_o <= seen_count;
  end

endmodule

// ----- verif/tb_border_marker_run_finder_core.sv -----
// Testbench top for the border marker run finder: stimulus, flow control and verdict.
module tb_border_marker_run_finder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CFG_SPARE    = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned RANDOM_WORDS = 1450;
  localparam int unsigned SAT_LEN      = 65542;
  localparam int unsigned TAIL_FROM    = 65520;
  // hit pattern of the last words of the long pass, bit k for word TAIL_FROM + k
  localparam logic [21:0] TAIL_HITS    = 22'h397FDF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = bmrf_pkg::CFG_BYTE_SEL;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic [31:0] pixel_word = 32'h0;
  logic        last_pixel = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] range_start;
  logic [15:0] range_end;
  logic        final_range;
  int unsigned mismatches;
  int unsigned ranges_due;
  int unsigned ranges_seen;

  logic [1:0]  cur_sel = 2'd3;
  logic [7:0]  cur_mask = 8'hFF;
  logic [7:0]  cur_match = 8'hFF;
  int unsigned words_sent = 0;
  int unsigned passes_sent = 0;
  int unsigned settings_used = 0;
  int unsigned random_words = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          holding = 1'b0;

  border_marker_run_finder_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_word_i (pixel_word),
    .last_pixel_i (last_pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .range_start_o(range_start),
    .range_end_o  (range_end),
    .final_range_o(final_range)
  );

  bmrf_range_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_word_i (pixel_word),
    .last_pixel_i (last_pixel),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .range_start_i(range_start),
    .range_end_i  (range_end),
    .final_range_i(final_range),
    .mismatches_o (mismatches),
    .ranges_due_o (ranges_due),
    .ranges_seen_o(ranges_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // receiver: stall segments of random shape, or one long hold-off on request
  initial begin
    int seg_mode;
    int seg_len;
    int k;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else begin
        seg_mode = $urandom_range(0, 3);
        seg_len  = $urandom_range(8, 60);
        for (k = 0; k < seg_len; k++) begin
          case (seg_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= (k % 3 == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [31:0] make_word(input logic want_hit);
    logic [31:0] w;
    logic [7:0]  b;
    int          tries;
    w     = $urandom;
    b     = w[8*cur_sel +: 8];
    tries = 0;
    if (want_hit) begin
      b = (b & ~cur_mask) | cur_match;
    end else begin
      while ((b & cur_mask) == cur_match && tries < 16) begin
        b = 8'($urandom);
        tries++;
      end
    end
    w[8*cur_sel +: 8] = b;
    return w;
  endfunction

  task automatic push_pixel(input logic [31:0] word, input logic last);
    in_valid   <= 1'b1;
    pixel_word <= word;
    last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ranges_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [7:0] sel_raw, input logic [7:0] mask,
                           input logic [7:0] match);
    put_reg(bmrf_pkg::CFG_BYTE_SEL, sel_raw);
    put_reg(bmrf_pkg::CFG_MASK, mask);
    put_reg(bmrf_pkg::CFG_MATCH, match);
    put_reg(CFG_SPARE, 8'($urandom));
    cfg_we    <= 1'b0;
    cur_sel   = sel_raw[1:0];
    cur_mask  = mask;
    cur_match = match;
    settings_used++;
  endtask

  task automatic random_pass(input int len, input int flip_pct, input int noise_pct);
    logic        hit;
    logic [31:0] w;
    int          i;
    hit = 1'($urandom_range(0, 1));
    for (i = 0; i < len; i++) begin
      if ($urandom_range(1, 100) <= flip_pct) hit = ~hit;
      w = ($urandom_range(1, 100) <= noise_pct) ? $urandom : make_word(hit);
      push_pixel(w, i == len - 1);
    end
    random_words += len;
    passes_sent++;
  endtask

  initial begin
    int          phase;
    int          len;
    int          i;
    int unsigned target;
    logic        hit;
    logic [7:0]  mask_v;
    logic [7:0]  match_v;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: top byte, full mask, 0xFF
    push_pixel(32'h0000_0000, 1'b1);
    push_pixel(32'hFFFF_FFFF, 1'b1);
    push_pixel(32'hFF00_0000, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'h00FF_FFFF, 1'b0);
    push_pixel(32'hFF00_0000, 1'b0);
    push_pixel(32'h7F00_0000, 1'b0);
    push_pixel(32'h0000_0000, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b1);
    passes_sent += 3;
    settle();
    // upper select bits dropped on write
    load_regs(8'hFC, 8'h0F, 8'h05);
    push_pixel(32'h0000_0005, 1'b0);
    push_pixel(32'hFFFF_FFF5, 1'b0);
    push_pixel(32'h0000_000A, 1'b1);
    settle();
    // match outside mask: fallback range only
    load_regs(8'h02, 8'h0F, 8'h15);
    push_pixel($urandom, 1'b0);
    push_pixel($urandom, 1'b0);
    push_pixel($urandom, 1'b1);
    settle();
    // match value changed in the middle of a pass
    load_regs(8'h01, 8'hFF, 8'h12);
    push_pixel(32'h0000_1200, 1'b0);
    push_pixel(32'hFFFF_12FF, 1'b0);
    push_pixel(32'h0000_3400, 1'b0);
    settle();
    load_regs(8'h01, 8'hFF, 8'h34);
    push_pixel(32'h0000_3400, 1'b0);
    push_pixel(32'h0000_1200, 1'b0);
    push_pixel(32'h1234_3456, 1'b1);
    passes_sent += 3;
    settle();

    // one pass long enough to run the position counter into its cap
    load_regs(8'h00, 8'hFF, 8'h3C);
    gaps_on = 1'b0;
    hit     = 1'b0;
    for (i = 0; i < SAT_LEN; i++) begin
      if (i < TAIL_FROM) begin
        if ($urandom_range(0, 99) < 2) hit = ~hit;
      end else begin
        hit = TAIL_HITS[i - TAIL_FROM];
      end
      push_pixel(make_word(hit), i == SAT_LEN - 1);
    end
    passes_sent++;

    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      settle();
      case (phase)
        0: load_regs(8'h00, 8'hFF, 8'h00);
        1: load_regs(8'h03, 8'h00, 8'h00);
        2: load_regs(8'hFE, 8'hFF, 8'hFF);
        default: begin
          case ($urandom_range(0, 3))
            0:       mask_v = 8'hFF;
            1:       mask_v = 8'h00;
            default: mask_v = 8'($urandom);
          endcase
          match_v = ($urandom_range(0, 4) == 0) ? 8'($urandom) : (8'($urandom) & mask_v);
          load_regs(8'($urandom), mask_v, match_v);
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // hold the receiver off while closing a run every other word
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        @(posedge clk);
        while (!holding) @(posedge clk);
        for (i = 0; i < 48; i++) push_pixel(make_word(i % 2 == 0), i == 47);
        random_words += 48;
        passes_sent++;
        gaps_on = 1'b1;
      end
      target = random_words + $urandom_range(80, 200);
      while (random_words < target) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        random_pass(len, $urandom_range(5, 60), ($urandom_range(0, 3) == 0) ? 20 : 0);
      end
      phase++;
    end

    settle();
    repeat (16) @(posedge clk);
    if (ranges_due != 0) $display("%0d expected ranges never arrived", ranges_due);
    $display("Sent %0d pixel words in %0d border passes over %0d register settings,",
             words_sent, passes_sent, settings_used);
    $display("one pass past the position cap, %0d ranges compared, %0d mismatches.",
             ranges_seen, mismatches);
    if (mismatches == 0 && ranges_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- border_marker_run_finder_core.f -----
rtl/bmrf_pkg.sv
rtl/bmrf_match.sv
rtl/bmrf_tracker.sv
rtl/bmrf_out_fifo.sv
rtl/border_marker_run_finder_core.sv
verif/bmrf_range_checker.sv
verif/tb_border_marker_run_finder_core.sv
